[design/bddv_pkg.sv]
// shared types and codes for the bounded deque with delete by value
// no dependencies
package bddv_pkg;

	localparam int VALUE_W = 32;

	// command codes carried on s_tuser
	localparam logic [1:0] CMD_INS_FRONT = 2'd0;
	localparam logic [1:0] CMD_INS_BACK  = 2'd1;
	localparam logic [1:0] CMD_DELETE    = 2'd2;
	localparam logic [1:0] CMD_DUMP      = 2'd3;

	// status codes carried on m_tuser
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_PUSH_FRONT,
		CM_PUSH_BACK,
		CM_DELETE,
		CM_ROTATE
	} chain_mode_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		chain_mode_t               mode;
		logic signed [VALUE_W-1:0] bus;
	} chain_ctrl_t;

endpackage

[design/bounded_deque_delete_by_value.sv]
// bounded ordered list of signed words kept in a chain of cells, front in cell 0
// a result is registered as the word is taken; a dump's first result in the next cycle
// one command at a time; a dump then gives one result per cycle while the output is taken
// and the chain rotates; insert, delete and an empty dump give only the one result
// reset: arst_n clears occupancy, sequencer state and output valid; cells are not reset
// depends on bddv_pkg, bddv_cell, bddv_ctrl
module bounded_deque_delete_by_value #(
	parameter int CAPACITY = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	input  logic [31:0]                                s_tdata,  // operand_value
	input  logic [1:0]                                 s_tuser,  // command
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// result_value, entry_count, zero fill
	output logic [((32 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [1:0]                                 m_tuser,  // status
	output logic                                       m_tlast   // last_of_run
);
	import bddv_pkg::*;

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int TDW = ((VALUE_W + CW + 7) / 8) * 8;
	localparam int PAD = TDW - VALUE_W - CW;

	chain_ctrl_t               ctrl;
	logic [CW-1:0]             occupancy;
	logic signed [VALUE_W-1:0] cell_value [CAPACITY];
	logic                      cell_match [CAPACITY];
	logic signed [VALUE_W-1:0] result_value;
	logic [CW-1:0]             entry_count;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_value;
		logic signed [VALUE_W-1:0] right_value;
		logic                      match_in;

		if (i == 0) begin : g_head
			assign left_value = ctrl.bus;
			assign match_in   = 1'b0;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign match_in   = cell_match[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_value = ctrl.bus;
		end else begin : g_mid
			assign right_value = cell_value[i+1];
		end

		bddv_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.valid       (occupancy > CW'(i)),
			.tail        (occupancy == CW'(i + 1)),
			.append      (occupancy == CW'(i)),
			.left_value  (left_value),
			.right_value (right_value),
			.match_in    (match_in),
			.value       (cell_value[i]),
			.match_out   (cell_match[i])
		);
	end

	bddv_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.command       (s_tuser),
		.operand_value (s_tdata),
		.found         (cell_match[CAPACITY-1]),
		.front_value   (cell_value[0]),
		.ctrl          (ctrl),
		.occupancy     (occupancy),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.status        (m_tuser),
		.result_value  (result_value),
		.entry_count   (entry_count),
		.last_of_run   (m_tlast)
	);

	assign m_tdata = {{PAD{1'b0}}, entry_count, result_value};

endmodule

[design/bddv_cell.sv]
// one storage cell of the ordered chain: holds one entry, compares it
// against the broadcast value and takes a neighbor's entry on a shift
// depends on bddv_pkg
module bddv_cell (
	input  logic                                 clk,
	input  bddv_pkg::chain_ctrl_t                ctrl,
	input  logic                                 valid,
	input  logic                                 tail,
	input  logic                                 append,
	input  logic signed [bddv_pkg::VALUE_W-1:0]  left_value,
	input  logic signed [bddv_pkg::VALUE_W-1:0]  right_value,
	input  logic                                 match_in,
	output logic signed [bddv_pkg::VALUE_W-1:0]  value,
	output logic                                 match_out
);
	import bddv_pkg::*;

	logic signed [VALUE_W-1:0] value_q;
	logic signed [VALUE_W-1:0] value_d;
	logic                      hit;

	assign hit       = valid && (value_q == ctrl.bus);
	assign match_out = match_in | hit;
	assign value     = value_q;

	always_comb begin
		case (ctrl.mode)
			CM_PUSH_FRONT: value_d = left_value;
			CM_PUSH_BACK:  value_d = append ? ctrl.bus : value_q;
			// every cell at or after the first match closes the gap
			CM_DELETE:     value_d = match_out ? right_value : value_q;
			// front word wraps to the tail
			CM_ROTATE:     value_d = tail ? ctrl.bus : right_value;
			default:       value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

[design/bddv_ctrl.sv]
// command sequencer: occupancy, dump counter, output register and the
// control broadcast to the cell chain
// depends on bddv_pkg
module bddv_ctrl #(
	parameter int CAPACITY = 16,
	parameter int CW       = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [1:0]                           command,
	input  logic signed [bddv_pkg::VALUE_W-1:0]  operand_value,
	input  logic                                 found,
	input  logic signed [bddv_pkg::VALUE_W-1:0]  front_value,
	output bddv_pkg::chain_ctrl_t                ctrl,
	output logic [CW-1:0]                        occupancy,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [1:0]                           status,
	output logic signed [bddv_pkg::VALUE_W-1:0]  result_value,
	output logic [CW-1:0]                        entry_count,
	output logic                                 last_of_run
);
	import bddv_pkg::*;

	state_t                    state_q, state_d;
	logic [CW-1:0]             occ_q, occ_d;
	logic [CW-1:0]             rem_q, rem_d;
	logic                      m_tvalid_q;
	logic [1:0]                status_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CW-1:0]             count_q;
	logic                      last_q;

	logic                      out_free;
	logic                      accept;
	logic                      is_full;
	logic                      is_empty;
	logic                      dump_last;
	logic                      out_load;
	logic [1:0]                out_status;
	logic signed [VALUE_W-1:0] out_value;
	logic [CW-1:0]             out_count;
	logic                      out_last;

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign is_full   = (occ_q == CW'(CAPACITY));
	assign is_empty  = (occ_q == '0);
	assign dump_last = (rem_q == CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && command == CMD_DUMP && !is_empty)
					state_d = S_DUMP;
			end
			S_DUMP: begin
				if (out_free && dump_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		ctrl.mode  = CM_HOLD;
		ctrl.bus   = operand_value;
		occ_d      = occ_q;
		rem_d      = rem_q;
		out_load   = 1'b0;
		out_status = STATUS_OK;
		out_value  = operand_value;
		out_count  = occ_q;
		out_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_INS_FRONT, CMD_INS_BACK: begin
							out_load = 1'b1;
							if (is_full) begin
								out_status = STATUS_FULL;
							end else begin
								ctrl.mode = (command == CMD_INS_FRONT) ?
									CM_PUSH_FRONT : CM_PUSH_BACK;
								occ_d     = occ_q + CW'(1);
							end
						end
						CMD_DELETE: begin
							out_load = 1'b1;
							if (is_empty) begin
								out_status = STATUS_EMPTY;
							end else if (!found) begin
								out_status = STATUS_NOTFOUND;
							end else begin
								ctrl.mode = CM_DELETE;
								occ_d     = occ_q - CW'(1);
							end
						end
						default: begin
							if (is_empty) begin
								out_load   = 1'b1;
								out_status = STATUS_EMPTY;
								out_value  = '0;
							end else begin
								rem_d = occ_q;
							end
						end
					endcase
					out_count = occ_d;
				end
			end
			S_DUMP: begin
				ctrl.bus  = front_value;
				out_value = front_value;
				out_last  = dump_last;
				if (out_free) begin
					ctrl.mode = CM_ROTATE;
					out_load  = 1'b1;
					rem_d     = rem_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			occ_q      <= '0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			rem_q   <= rem_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= out_status;
			value_q  <= out_value;
			count_q  <= out_count;
			last_q   <= out_last;
		end
	end

	assign occupancy    = occ_q;
	assign m_tvalid     = m_tvalid_q;
	assign status       = status_q;
	assign result_value = value_q;
	assign entry_count  = count_q;
	assign last_of_run  = last_q;

endmodule
